// ===== rtl/core/uae_pkg.sv =====
// Shared types and constants for the ungapped alignment extension block.
// Used by uae_core and the ungapped_alignment_extension top level.
package uae_pkg;

    // Field widths
    localparam int BASE_W  = 8;
    localparam int LEN_W   = 13;
    localparam int FRAC_W  = 17;
    localparam int SPM_W   = 4;
    localparam int SCORE_W = 18;   // running score, +/- 15 * 4096
    localparam int OSC_W   = 31;   // max_score result field
    localparam int CAP_W   = 31;   // fraction * (prior + length)
    localparam int TMM_W   = LEN_W + 1;

    // Longest extension that is worked on; longer lengths saturate here
    localparam logic [LEN_W-1:0] MAX_EXT_LEN = LEN_W'(4096);

    // Base codes
    localparam logic [BASE_W-1:0] EDGE_CODE     = BASE_W'(5);
    localparam logic [BASE_W-1:0] MAX_BASE_CODE = BASE_W'(3);

    // Score given when an end-to-end run reaches a chromosome edge
    localparam logic signed [OSC_W-1:0] EDGE_SCORE = -OSC_W'(999999999);

    // Register reset values
    localparam logic [LEN_W-1:0]  RST_MM_LIMIT = LEN_W'(10);
    localparam logic [FRAC_W-1:0] RST_MM_FRAC  = FRAC_W'(19661);
    localparam logic [SPM_W-1:0]  RST_SCORE    = SPM_W'(1);
    localparam logic [BASE_W-1:0] RST_SPACER   = BASE_W'(11);

    // Stream packing
    localparam int IN_DATA_W  = 56;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 72;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MM_LIMIT = 2'd0,
        CFG_MM_FRAC  = 2'd1,
        CFG_SCORE    = 2'd2,
        CFG_SPACER   = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [LEN_W-1:0]  mismatch_limit;
        logic [FRAC_W-1:0] mismatch_fraction_q16;
        logic [SPM_W-1:0]  score_per_match;
        logic [BASE_W-1:0] spacer_code;
    } t_cfg;

    typedef struct packed {
        logic [BASE_W-1:0] read_base;
        logic [BASE_W-1:0] genome_base;
        logic              genome_wrapped;
        logic              first_pair;
        logic              last_pair;
        logic              end_to_end;
        logic [LEN_W-1:0]  extension_length;
        logic [LEN_W-1:0]  prior_length;
        logic [LEN_W-1:0]  prior_mismatches;
    } t_item;

    typedef struct packed {
        logic                    extended;
        logic [LEN_W-1:0]        extend_len;
        logic signed [OSC_W-1:0] max_score;
        logic [LEN_W-1:0]        match_count;
        logic [LEN_W-1:0]        mismatch_count;
    } t_result;

endpackage

// ===== rtl/core/uae_core.sv =====
// Run state and per-pair scoring for the ungapped alignment extension.
// Depends on uae_pkg; updates once per advanced word, result from next state.
module uae_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_go,
    input  uae_pkg::t_item    i_item,
    input  uae_pkg::t_cfg     i_cfg,
    output uae_pkg::t_result  o_result
);
    import uae_pkg::*;

    logic signed [SCORE_W-1:0] r_score, n_score, r_best_score, n_best_score;
    logic [LEN_W-1:0]  r_mt, n_mt, r_mm, n_mm, r_pi, n_pi;
    logic [LEN_W-1:0]  r_best_len, n_best_len, r_best_mt, n_best_mt, r_best_mm, n_best_mm;
    logic [LEN_W-1:0]  r_len, n_len, r_prior_len, n_prior_len, r_prior_mm, n_prior_mm;
    logic [CAP_W-1:0]  r_stop_cap, n_stop_cap;
    logic              r_mode, n_mode, r_stopped, n_stopped, r_boundary, n_boundary;

    // Start-of-run view: cleared and freshly latched on a first pair
    logic signed [SCORE_W-1:0] b_score, b_best_score;
    logic [LEN_W-1:0]  b_mt, b_mm, b_pi, b_best_len, b_best_mt, b_best_mm;
    logic [LEN_W-1:0]  b_prior_len, b_prior_mm;
    logic              b_stopped, b_boundary;
    logic [LEN_W-1:0]  sat_len;
    logic [TMM_W-1:0]  cap_len, bud_len, total_mm;
    logic [CAP_W-1:0]  start_cap, budget, mm_scaled;
    logic signed [SCORE_W-1:0] spm, score_up, score_dn;
    logic              edge_hit, spacer_hit, bases_ok, active;

    always_comb begin
        sat_len   = (i_item.extension_length > MAX_EXT_LEN) ? MAX_EXT_LEN
                                                           : i_item.extension_length;
        cap_len   = TMM_W'(i_item.prior_length) + TMM_W'(sat_len);
        start_cap = CAP_W'(i_cfg.mismatch_fraction_q16) * CAP_W'(cap_len);

        if (i_item.first_pair) begin
            b_score = '0; b_best_score = '0;
            b_mt = '0; b_mm = '0; b_pi = '0;
            b_best_len = '0; b_best_mt = '0; b_best_mm = '0;
            b_stopped = 1'b0; b_boundary = 1'b0;
            b_prior_len = i_item.prior_length;
            b_prior_mm  = i_item.prior_mismatches;
            n_mode      = i_item.end_to_end;
            n_len       = sat_len;
            n_stop_cap  = start_cap;
        end else begin
            b_score = r_score; b_best_score = r_best_score;
            b_mt = r_mt; b_mm = r_mm; b_pi = r_pi;
            b_best_len = r_best_len; b_best_mt = r_best_mt; b_best_mm = r_best_mm;
            b_stopped = r_stopped; b_boundary = r_boundary;
            b_prior_len = r_prior_len;
            b_prior_mm  = r_prior_mm;
            n_mode      = r_mode;
            n_len       = r_len;
            n_stop_cap  = r_stop_cap;
        end
        n_prior_len = b_prior_len;
        n_prior_mm  = b_prior_mm;

        // Budget for a prefix ending at this pair: fraction * aligned length
        bud_len   = TMM_W'(b_prior_len) + TMM_W'(b_pi) + TMM_W'(1);
        budget    = CAP_W'(i_cfg.mismatch_fraction_q16) * CAP_W'(bud_len);
        total_mm  = TMM_W'(b_mm) + TMM_W'(b_prior_mm);
        mm_scaled = {1'b0, total_mm, 16'b0};

        spm        = SCORE_W'($signed({1'b0, i_cfg.score_per_match}));
        score_up   = b_score + spm;
        score_dn   = b_score - spm;
        edge_hit   = i_item.genome_wrapped || (i_item.genome_base == EDGE_CODE);
        spacer_hit = (i_item.read_base == i_cfg.spacer_code);
        bases_ok   = (i_item.read_base <= MAX_BASE_CODE) &&
                     (i_item.genome_base <= MAX_BASE_CODE);
        active     = !b_stopped && (b_pi < n_len);

        n_score = b_score; n_best_score = b_best_score;
        n_mt = b_mt; n_mm = b_mm; n_pi = b_pi;
        n_best_len = b_best_len; n_best_mt = b_best_mt; n_best_mm = b_best_mm;
        n_stopped = b_stopped; n_boundary = b_boundary;

        if (active) begin
            if (edge_hit || spacer_hit) begin
                // End-to-end mode flags the edge; spacer only halts
                n_stopped = 1'b1;
                if (n_mode && edge_hit) begin
                    n_boundary = 1'b1;
                end
            end else if (bases_ok && (i_item.read_base == i_item.genome_base)) begin
                n_mt    = b_mt + LEN_W'(1);
                n_score = score_up;
                n_pi    = b_pi + LEN_W'(1);
                if (!n_mode && (score_up > b_best_score) && (mm_scaled <= budget) &&
                    (total_mm <= TMM_W'(i_cfg.mismatch_limit))) begin
                    n_best_len   = b_pi + LEN_W'(1);
                    n_best_score = score_up;
                    n_best_mt    = b_mt + LEN_W'(1);
                    n_best_mm    = b_mm;
                end
            end else if (bases_ok) begin
                // Local mode: drop out once the full-length budget or the mismatch limit is spent
                if (!n_mode && ((mm_scaled >= n_stop_cap) ||
                                (total_mm >= TMM_W'(i_cfg.mismatch_limit)))) begin
                    n_stopped = 1'b1;
                end else begin
                    n_mm    = b_mm + LEN_W'(1);
                    n_score = score_dn;
                    n_pi    = b_pi + LEN_W'(1);
                end
            end else begin
                n_pi = b_pi + LEN_W'(1);
            end
        end

        if (i_item.last_pair) begin
            n_stopped = 1'b1;
        end
    end

    // Result as seen after this pair
    always_comb begin
        o_result = '0;
        if (n_mode) begin
            if (n_boundary) begin
                o_result.extended       = 1'b1;
                o_result.max_score      = EDGE_SCORE;
                o_result.mismatch_count = i_cfg.mismatch_limit + LEN_W'(1);
            end else if (n_pi != '0) begin
                o_result.extended       = 1'b1;
                o_result.extend_len     = n_pi;
                o_result.max_score      = OSC_W'(n_score);
                o_result.match_count    = n_mt;
                o_result.mismatch_count = n_mm;
            end
        end else if (n_best_len != '0) begin
            o_result.extended       = 1'b1;
            o_result.extend_len     = n_best_len;
            o_result.max_score      = OSC_W'(n_best_score);
            o_result.match_count    = n_best_mt;
            o_result.mismatch_count = n_best_mm;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_score <= '0; r_best_score <= '0;
            r_mt <= '0; r_mm <= '0; r_pi <= '0;
            r_best_len <= '0; r_best_mt <= '0; r_best_mm <= '0;
            r_len <= '0; r_prior_len <= '0; r_prior_mm <= '0;
            r_stop_cap <= '0;
            r_mode <= 1'b0; r_stopped <= 1'b0; r_boundary <= 1'b0;
        end else if (i_go) begin
            r_score <= n_score; r_best_score <= n_best_score;
            r_mt <= n_mt; r_mm <= n_mm; r_pi <= n_pi;
            r_best_len <= n_best_len; r_best_mt <= n_best_mt; r_best_mm <= n_best_mm;
            r_len <= n_len; r_prior_len <= n_prior_len; r_prior_mm <= n_prior_mm;
            r_stop_cap <= n_stop_cap;
            r_mode <= n_mode; r_stopped <= n_stopped; r_boundary <= n_boundary;
        end
    end

    a_best_within_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_best_len <= r_pi)
        else $error("best extension longer than pairs processed");

    a_counts_within_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (TMM_W'(r_mt) + TMM_W'(r_mm)) <= TMM_W'(r_pi))
        else $error("match and mismatch counts exceed pairs processed");

    a_no_best_end_to_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mode |-> (r_best_len == '0))
        else $error("best prefix recorded in end-to-end mode");

    a_boundary_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_boundary |-> (r_mode && r_stopped))
        else $error("edge flag without a stopped end-to-end run");

    a_stopped_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_stopped && !(i_go && i_item.first_pair)) |=> $stable(r_pi))
        else $error("pair index moved after the run stopped");

endmodule

// ===== rtl/core/ungapped_alignment_extension.sv =====
// Top level of the ungapped alignment extension: stream ports, config registers,
// input and result registers around uae_core. Depends on uae_pkg and uae_core.
//
// Result path: input register, then on a last pair the result register drives o_m_tdata.
// Throughput: one pair per cycle unless stalled; run state updates by one add/compare pass.
// Stalls: a last pair waits in the input register only while an untaken result is held.
// Reset: synchronous, active low; run state clears, config returns to its defaults.
module ungapped_alignment_extension (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Pair stream
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    // [7:0] read_base, [15:8] genome_base, [16] genome_wrapped,
    // [29:17] extension_length, [42:30] prior_length, [55:43] prior_mismatches
    input  logic [uae_pkg::IN_DATA_W-1:0]     i_s_tdata,
    // [0] first_pair, [1] end_to_end
    input  logic [uae_pkg::IN_USER_W-1:0]     i_s_tuser,
    input  logic                              i_s_tlast,   // last_pair
    // Result stream
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    // [12:0] extend_len, [43:13] max_score, [56:44] match_count,
    // [69:57] mismatch_count, [71:70] zero
    output logic [uae_pkg::OUT_DATA_W-1:0]    o_m_tdata,
    output logic                              o_m_tuser,   // extended
    // Configuration writes
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [uae_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [uae_pkg::FRAC_W-1:0]        i_cfg_data
);
    import uae_pkg::*;

    t_cfg    r_cfg;
    t_item   r_item;
    logic    r_item_valid;
    t_result r_res;
    logic    r_res_valid;

    t_item   in_item;
    t_result core_res;
    logic    out_free, item_go;

    // Unpack the incoming word
    always_comb begin
        in_item.read_base        = i_s_tdata[7:0];
        in_item.genome_base      = i_s_tdata[15:8];
        in_item.genome_wrapped   = i_s_tdata[16];
        in_item.extension_length = i_s_tdata[29:17];
        in_item.prior_length     = i_s_tdata[42:30];
        in_item.prior_mismatches = i_s_tdata[55:43];
        in_item.first_pair       = i_s_tuser[0];
        in_item.end_to_end       = i_s_tuser[1];
        in_item.last_pair        = i_s_tlast;
    end

    // A held pair advances unless it carries a result and the result slot is full
    assign out_free   = !r_res_valid || i_m_tready;
    assign item_go    = r_item_valid && (!r_item.last_pair || out_free);
    assign o_s_tready = !r_item_valid || item_go;

    // Config writes are always taken
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mismatch_limit        <= RST_MM_LIMIT;
            r_cfg.mismatch_fraction_q16 <= RST_MM_FRAC;
            r_cfg.score_per_match       <= RST_SCORE;
            r_cfg.spacer_code           <= RST_SPACER;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_MM_LIMIT: r_cfg.mismatch_limit        <= i_cfg_data[LEN_W-1:0];
                CFG_MM_FRAC:  r_cfg.mismatch_fraction_q16 <= i_cfg_data;
                CFG_SCORE:    r_cfg.score_per_match       <= i_cfg_data[SPM_W-1:0];
                CFG_SPACER:   r_cfg.spacer_code           <= i_cfg_data[BASE_W-1:0];
                default:      r_cfg <= r_cfg;
            endcase
        end
    end

    // Input register: load a word whenever the slot is free or draining
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_item_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_item <= in_item;
        end
    end

    uae_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_go     (item_go),
        .i_item   (r_item),
        .i_cfg    (r_cfg),
        .o_result (core_res)
    );

    // Result register: capture on the last pair, drop once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if (item_go && r_item.last_pair) begin
            r_res_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_res_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (item_go && r_item.last_pair) begin
            r_res <= core_res;
        end
    end

    assign o_m_tvalid = r_res_valid;
    assign o_m_tuser  = r_res.extended;
    assign o_m_tdata  = {2'b00, r_res.mismatch_count, r_res.match_count,
                         r_res.max_score, r_res.extend_len};

endmodule
